### hw/rtl/deoc_pkg.sv
// Shared command codes, queue sizing and result flag type for the overflow checker.
package deoc_pkg;

	localparam logic [1:0] CMD_FIRST  = 2'd0;
	localparam logic [1:0] CMD_SECOND = 2'd1;
	localparam logic [1:0] CMD_END    = 2'd2;

	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_PTR_W = 1;

	typedef struct packed {
		logic first_too_big;
		logic second_too_big;
		logic result_too_big;
	} flags_t;

endpackage

### hw/rtl/decimal_expression_overflow_check.sv
// Decimal expression overflow check: one digit or end word per cycle; the front end takes
// a word every cycle while the two-entry queue has room, and each end word yields one result
// word via the queue, the single product/sum stage and the output register, at a sustained rate
// of one per cycle while out_ready holds. Operands saturate at 2^VALUE_BITS; the three flags
// report first operand, second operand, and the exact sum or product above 2^VALUE_BITS - 1.
module decimal_expression_overflow_check import deoc_pkg::*; #(
	parameter int VALUE_BITS = 31
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] cmd,
	input  logic [3:0] digit,
	input  logic       is_multiply,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       first_too_big,
	output logic       second_too_big,
	output logic       result_too_big
);

	localparam int QW = 2 * VALUE_BITS + 3;

	logic          q_full;
	logic          push;
	logic [QW-1:0] push_data;
	logic          pop;
	logic          q_valid;
	logic [QW-1:0] q_data;
	flags_t        flags;

	deoc_front #(.VALUE_BITS(VALUE_BITS)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.cmd         (cmd),
		.digit       (digit),
		.is_multiply (is_multiply),
		.q_full      (q_full),
		.push        (push),
		.push_data   (push_data)
	);

	deoc_queue #(.WIDTH(QW)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (pop),
		.q_valid   (q_valid),
		.q_data    (q_data)
	);

	deoc_back #(.VALUE_BITS(VALUE_BITS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_data    (q_data),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.flags     (flags)
	);

	assign first_too_big  = flags.first_too_big;
	assign second_too_big = flags.second_too_big;
	assign result_too_big = flags.result_too_big;

endmodule

### hw/rtl/deoc_front.sv
// Front end: accepts words, accumulates operand digits, posts finished expressions.
module deoc_front import deoc_pkg::*; #(
	parameter int VALUE_BITS = 31
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [1:0]                cmd,
	input  logic [3:0]                digit,
	input  logic                      is_multiply,
	input  logic                      q_full,
	output logic                      push,
	output logic [2*VALUE_BITS+2:0]   push_data
);

	localparam int AW = VALUE_BITS + 1;
	localparam int EW = VALUE_BITS + 5;
	localparam logic [EW-1:0] SAT_EXT = {{(EW-1){1'b0}}, 1'b1} << VALUE_BITS;

	logic [AW-1:0] first_q;
	logic [AW-1:0] second_q;
	logic          accept;

	function automatic logic [AW-1:0] acc_step(input logic [AW-1:0] acc, input logic [3:0] d);
		logic [EW-1:0] t;
		t = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {{(EW-4){1'b0}}, d};
		if (t > SAT_EXT) begin
			t = SAT_EXT;
		end
		return t[AW-1:0];
	endfunction

	assign in_ready  = !q_full;
	assign accept    = in_valid && in_ready;
	assign push      = accept && (cmd == CMD_END);
	assign push_data = {first_q, second_q, is_multiply};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q  <= '0;
			second_q <= '0;
		end else if (accept) begin
			case (cmd)
				CMD_FIRST:  first_q  <= acc_step(first_q, digit);
				CMD_SECOND: second_q <= acc_step(second_q, digit);
				CMD_END: begin
					first_q  <= '0;
					second_q <= '0;
				end
				default: ; // drop unused command
			endcase
		end
	end

endmodule

### hw/rtl/deoc_queue.sv
// Short register queue between the front end and the evaluation back end.
module deoc_queue import deoc_pkg::*; #(
	parameter int WIDTH = 65
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic             q_valid,
	output logic [WIDTH-1:0] q_data
);

	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	logic [WIDTH-1:0]       mem_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wptr_q;
	logic [QUEUE_PTR_W-1:0] rptr_q;
	logic [CW-1:0]          cnt_q;
	logic                   do_push;
	logic                   do_pop;

	assign full    = (cnt_q == CW'(QUEUE_DEPTH));
	assign q_valid = (cnt_q != '0);
	assign q_data  = mem_q[rptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && q_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

### hw/rtl/deoc_back.sv
// Back end: forms the sum or product and registers the three overflow flags.
module deoc_back import deoc_pkg::*; #(
	parameter int VALUE_BITS = 31
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    q_valid,
	input  logic [2*VALUE_BITS+2:0] q_data,
	output logic                    pop,
	output logic                    out_valid,
	input  logic                    out_ready,
	output flags_t                  flags
);

	localparam int AW = VALUE_BITS + 1;
	localparam int PW = 2 * AW;
	localparam int SW = AW + 1;

	logic [AW-1:0] a;
	logic [AW-1:0] b;
	logic          mul;

	logic          valid_s1;
	logic [PW-1:0] prod_s1;
	logic [SW-1:0] sum_s1;
	logic          mul_s1;
	logic          a_sat_s1;
	logic          b_sat_s1;

	logic          out_valid_q;
	flags_t        flags_q;
	logic          adv2;

	assign {a, b, mul} = q_data;

	assign adv2      = valid_s1 && (!out_valid_q || out_ready);
	assign pop       = q_valid && (!valid_s1 || adv2);
	assign out_valid = out_valid_q;
	assign flags     = flags_q;

	always_ff @(posedge clk) begin
		if (pop) begin
			prod_s1  <= PW'(a) * PW'(b);
			sum_s1   <= SW'(a) + SW'(b);
			mul_s1   <= mul;
			a_sat_s1 <= a[AW-1];
			b_sat_s1 <= b[AW-1];
		end
		if (adv2) begin
			flags_q.first_too_big  <= a_sat_s1;
			flags_q.second_too_big <= b_sat_s1;
			// anything at or above 2^VALUE_BITS is past the limit
			flags_q.result_too_big <= mul_s1 ? (|prod_s1[PW-1:VALUE_BITS])
			                                 : (|sum_s1[SW-1:VALUE_BITS]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				valid_s1 <= 1'b1;
			end else if (adv2) begin
				valid_s1 <= 1'b0;
			end
			if (adv2) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |=> out_valid_q && $stable(flags_q))
		else $error("result word changed while stalled");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv2 |=> valid_s1)
		else $error("stage one lost its entry");

	a_no_pop_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_valid_q && !out_ready |-> !pop)
		else $error("queue popped into a blocked stage");

	a_zero_product_ok: assert property (@(posedge clk) disable iff (!arst_n)
		adv2 && mul_s1 && (prod_s1 == '0) |=> !flags_q.result_too_big)
		else $error("zero product flagged as overflow");

endmodule
